// ===== rtl/fba_pkg.sv =====
// shared types and codes for the fixed block allocator
`default_nettype none

package fba_pkg;

   // operation carried by an input word
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // result status codes
   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_NONE_FREE  = 3'd1,
      STAT_NULL       = 3'd2,
      STAT_RANGE      = 3'd3,
      STAT_MISALIGNED = 3'd4
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   // flags scanned per cycle during the free block search
   localparam int unsigned GROUP_FLAGS = 8;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic scan_step;
      logic div_step;
      logic commit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_free_op;
      logic addr_err;
      logic pool_full;
      logic scan_hit;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/fba_ctrl.sv =====
// controller state machine for the fixed block allocator
`default_nettype none

module fba_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire fba_pkg::stat_type stat,
   output fba_pkg::cmd_type      cmd
);

   fba_pkg::state_type state_ff;
   fba_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fba_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fba_pkg::ST_CHECK;
            end
         end
         fba_pkg::ST_CHECK: begin
            if (stat.is_free_op) begin
               state_in = stat.addr_err ? fba_pkg::ST_COMMIT : fba_pkg::ST_DIVIDE;
            end else begin
               state_in = stat.pool_full ? fba_pkg::ST_COMMIT : fba_pkg::ST_SCAN;
            end
         end
         fba_pkg::ST_SCAN: begin
            if (stat.scan_hit) begin
               state_in = fba_pkg::ST_COMMIT;
            end
         end
         fba_pkg::ST_DIVIDE: begin
            if (stat.div_last) begin
               state_in = fba_pkg::ST_COMMIT;
            end
         end
         fba_pkg::ST_COMMIT: begin
            if (stat.out_free) begin
               state_in = fba_pkg::ST_IDLE;
            end
         end
         default: state_in = fba_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         fba_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         fba_pkg::ST_CHECK: begin
         end
         fba_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         fba_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         fba_pkg::ST_COMMIT: begin
            cmd.commit = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/fba_dpath.sv =====
// datapath of the fixed block allocator: used flags, search, divider, result register
`default_nettype none

module fba_dpath #(
   parameter int unsigned NUM_BLOCKS  = 32,
   parameter int unsigned BLOCK_BYTES = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [31:0]       csr_wr_data,
   input  wire logic              req_op,
   input  wire logic [31:0]       req_block_addr,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [31:0]            rsp_grant_addr,
   output logic [4:0]             rsp_block_index,
   output logic                   rsp_pool_full,
   input  wire fba_pkg::cmd_type  cmd,
   output fba_pkg::stat_type      stat
);

   localparam int unsigned GF         = fba_pkg::GROUP_FLAGS;
   localparam int unsigned NUM_GRP    = (NUM_BLOCKS + GF - 1) / GF;
   localparam int unsigned GRP_W      = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
   localparam int unsigned SCAN_W     = NUM_GRP * GF;
   localparam int unsigned POS_W      = $clog2(GF);
   localparam int unsigned IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int unsigned IDXE_W     = (IDX_W > 5) ? IDX_W : 5;
   localparam int unsigned POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
   localparam int unsigned LAST_OFF   = POOL_BYTES - BLOCK_BYTES;
   localparam int unsigned OFF_W      = $clog2(POOL_BYTES);
   localparam int unsigned CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int unsigned BB_W       = $clog2(BLOCK_BYTES + 1);
   localparam int unsigned PROD_W     = IDX_W + BB_W;

   // configuration register
   logic [31:0] heap_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
      end else if (csr_wr_en) begin
         heap_base_ff <= csr_wr_data;
      end
   end

   // captured word and early address checks
   fba_pkg::op_type   op_ff,    op_in;
   logic              null_ff,  null_in;
   logic              range_ff, range_in;
   logic [31:0]       off_in;

   assign off_in   = req_block_addr - heap_base_ff;
   assign op_in    = fba_pkg::op_type'(req_op);
   assign null_in  = (req_block_addr == 32'd0);
   assign range_in = (off_in > 32'(LAST_OFF));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_in;
         null_ff  <= null_in;
         range_ff <= range_in;
      end
   end

   // used flags and used count
   logic [NUM_BLOCKS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]      cnt_ff,  cnt_in;
   logic                  full_now;

   assign full_now = (cnt_ff == CNT_W'(NUM_BLOCKS));

   // first fit search, one group of flags per cycle
   logic [SCAN_W-1:0]   scan_vec;
   logic [GF-1:0]       grp_flags;
   logic [POS_W-1:0]    hit_pos;
   logic                hit_now;
   logic [GRP_W-1:0]    grp_ff, grp_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   always_comb begin
      scan_vec                 = '1;
      scan_vec[NUM_BLOCKS-1:0] = used_ff;
   end

   assign grp_flags = scan_vec[{grp_ff, POS_W'(0)} +: GF];

   // lowest clear flag in the group
   always_comb begin
      hit_pos = '0;
      hit_now = 1'b0;
      for (int i = GF - 1; i >= 0; i--) begin
         if (!grp_flags[i]) begin
            hit_pos = POS_W'(i);
            hit_now = 1'b1;
         end
      end
   end

   always_comb begin
      grp_in = grp_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         grp_in = '0;
      end else if (cmd.scan_step) begin
         if (hit_now) begin
            idx_in = IDX_W'({grp_ff, hit_pos});
         end else begin
            grp_in = grp_ff + GRP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      idx_ff <= idx_in;
   end

   // release index: first step takes the offset times the rounded-up reciprocal of
   // the block size, second step compares the index times the block size with the
   // offset to find a misaligned address
   localparam int unsigned     RCP_SH = OFF_W + BB_W;
   localparam int unsigned     RCP_W  = OFF_W + 2;
   localparam int unsigned     MUL_W  = OFF_W + RCP_W;
   localparam longint unsigned RCP_M  =
      ((64'd1 << RCP_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

   logic [OFF_W-1:0]  off_ff;
   logic [MUL_W-1:0]  rcp_prod;
   logic [PROD_W-1:0] quo_prod;
   logic [IDX_W-1:0]  quo_ff,   quo_in;
   logic              mis_ff,   mis_in;
   logic              dstep_ff, dstep_in;

   assign rcp_prod = MUL_W'(off_ff) * MUL_W'(RCP_M);
   assign quo_prod = PROD_W'(quo_ff) * PROD_W'(BLOCK_BYTES);

   always_comb begin
      quo_in   = quo_ff;
      mis_in   = mis_ff;
      dstep_in = dstep_ff;
      if (cmd.load) begin
         dstep_in = 1'b0;
      end else if (cmd.div_step) begin
         if (!dstep_ff) begin
            quo_in = IDX_W'(rcp_prod >> RCP_SH);
         end else begin
            mis_in = (PROD_W'(off_ff) != quo_prod);
         end
         dstep_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         off_ff <= off_in[OFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      mis_ff   <= mis_in;
      dstep_ff <= dstep_in;
   end

   // grant address
   logic [PROD_W-1:0] grant_off;
   logic [31:0]       grant_addr;

   assign grant_off  = PROD_W'(idx_ff) * PROD_W'(BLOCK_BYTES);
   assign grant_addr = heap_base_ff + 32'(grant_off);

   // result of the step and flag update
   fba_pkg::status_type res_status;
   logic [31:0]         res_addr;
   logic [IDX_W-1:0]    res_idx;
   logic [IDXE_W-1:0]   res_idx_ext;

   always_comb begin
      res_status = fba_pkg::STAT_OK;
      res_addr   = '0;
      res_idx    = '0;
      used_in    = used_ff;
      cnt_in     = cnt_ff;
      if (op_ff == fba_pkg::OP_ALLOC) begin
         if (full_now) begin
            res_status = fba_pkg::STAT_NONE_FREE;
         end else begin
            res_addr        = grant_addr;
            res_idx         = idx_ff;
            used_in[idx_ff] = 1'b1;
            cnt_in          = cnt_ff + CNT_W'(1);
         end
      end else begin
         priority if (null_ff) begin
            res_status = fba_pkg::STAT_NULL;
         end else if (range_ff) begin
            res_status = fba_pkg::STAT_RANGE;
         end else if (mis_ff) begin
            res_status = fba_pkg::STAT_MISALIGNED;
         end else begin
            res_idx = quo_ff;
            if (used_ff[quo_ff]) begin
               used_in[quo_ff] = 1'b0;
               cnt_in          = cnt_ff - CNT_W'(1);
            end
         end
      end
   end

   assign res_idx_ext = IDXE_W'(res_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.commit) begin
         used_ff <= used_in;
         cnt_ff  <= cnt_in;
      end
   end

   // output word register
   logic                rsp_valid_ff, rsp_valid_in;
   fba_pkg::status_type rsp_status_ff;
   logic [31:0]         rsp_addr_ff;
   logic [4:0]          rsp_idx_ff;
   logic                rsp_full_ff;
   logic                out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= res_status;
         rsp_addr_ff   <= res_addr;
         rsp_idx_ff    <= res_idx_ext[4:0];
         rsp_full_ff   <= (cnt_in == CNT_W'(NUM_BLOCKS));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = 3'(rsp_status_ff);
   assign rsp_grant_addr  = rsp_addr_ff;
   assign rsp_block_index = rsp_idx_ff;
   assign rsp_pool_full   = rsp_full_ff;

   // status to controller
   always_comb begin
      stat            = '0;
      stat.is_free_op = (op_ff == fba_pkg::OP_FREE);
      stat.addr_err   = null_ff || range_ff;
      stat.pool_full  = full_now;
      stat.scan_hit   = hit_now;
      stat.div_last   = dstep_ff;
      stat.out_free   = out_free;
   end

endmodule

`default_nettype wire

// ===== rtl/fixed_block_allocator_unit.sv =====
// top level of the fixed block allocator
// Hands out equal blocks of BLOCK_BYTES bytes from a pool of NUM_BLOCKS blocks
// starting at heap_base (csr_wr_data, written with csr_wr_en while idle; reset 0).
// req_op 0 grants the lowest free block and returns heap_base + index * BLOCK_BYTES,
// or status none free when all are in use; req_op 1 releases req_block_addr after
// null, range and alignment checks, in that order. Every input word gives exactly
// one result word, which also reports whether the pool is full afterwards. The used
// flags are cleared by reset, so the block takes words right away. One word is in
// work at a time. An accepted word passes a check state; a request then searches
// the used flags in groups of eight, one group per cycle, lowest first; a release
// that is neither null nor out of range runs the divider: block index by reciprocal
// multiplication, then the alignment check. A full pool or a null or out of range
// address goes straight to the result register. A result still held by rsp_stall
// delays the register of the next one. A new word is taken in the cycle after the
// result is registered, even while that result still waits on rsp_stall.
`default_nettype none

module fixed_block_allocator_unit #(
   parameter int unsigned NUM_BLOCKS  = 32,
   parameter int unsigned BLOCK_BYTES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [31:0] req_block_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_grant_addr,
   output logic [4:0]       rsp_block_index,
   output logic             rsp_pool_full
);

   fba_pkg::cmd_type  cmd;
   fba_pkg::stat_type stat;

   // sequencing
   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // flags, search, divider and result word
   fba_dpath #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_op          (req_op),
      .req_block_addr  (req_block_addr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_grant_addr  (rsp_grant_addr),
      .rsp_block_index (rsp_block_index),
      .rsp_pool_full   (rsp_pool_full),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

`default_nettype wire

// ===== test/tb_fixed_block_allocator_unit.sv =====
// self-checking testbench for the fixed block allocator
`default_nettype none

module tb_fixed_block_allocator_unit;

   localparam int unsigned NUM_BLOCKS  = 32;
   localparam int unsigned BLOCK_BYTES = 128;
   localparam int unsigned POOL_BYTES  = NUM_BLOCKS * BLOCK_BYTES;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE_TICKS = 12;
   localparam int HOLD_TICKS   = 80;

   // one expected result word
   typedef struct packed {
      fba_pkg::status_type status;
      logic [31:0]         grant_addr;
      logic [4:0]          block_index;
      logic                pool_full;
   } alloc_reply_type;

   // tracks the used flags and the heap base, and owes one reply per accepted word
   class alloc_scoreboard_type;
      logic [31:0]     heap_base;
      logic            used_map [NUM_BLOCKS];
      alloc_reply_type replies_due [$];
      int              failures;
      int              reports;

      function new();
         heap_base = '0;
         foreach (used_map[k]) used_map[k] = 1'b0;
         failures = 0;
         reports  = 0;
      endfunction

      function bit all_used();
         foreach (used_map[k]) if (!used_map[k]) return 1'b0;
         return 1'b1;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      // predict the reply of an accepted word and update the flags
      function void note_word(fba_pkg::op_type op, logic [31:0] addr);
         alloc_reply_type r;
         logic [31:0]     offset;
         logic [31:0]     index;
         bit              found;
         r = '{status: fba_pkg::STAT_OK, grant_addr: '0, block_index: '0, pool_full: 1'b0};
         found = 1'b0;
         if (op == fba_pkg::OP_ALLOC) begin
            // lowest free block wins
            for (int k = 0; k < NUM_BLOCKS; k++) begin
               if (!found && !used_map[k]) begin
                  found = 1'b1;
                  used_map[k] = 1'b1;
                  r.grant_addr  = heap_base + 32'(k * BLOCK_BYTES);
                  r.block_index = 5'(k);
               end
            end
            if (!found) r.status = fba_pkg::STAT_NONE_FREE;
         end else begin
            // null, then range, then alignment
            offset = addr - heap_base;
            if (addr == 32'h0) begin
               r.status = fba_pkg::STAT_NULL;
            end else if (offset > POOL_BYTES - BLOCK_BYTES) begin
               r.status = fba_pkg::STAT_RANGE;
            end else if (offset % BLOCK_BYTES != 0) begin
               r.status = fba_pkg::STAT_MISALIGNED;
            end else begin
               index = offset / BLOCK_BYTES;
               used_map[index] = 1'b0;
               r.block_index = index[4:0];
            end
         end
         r.pool_full = all_used();
         replies_due.push_back(r);
      endfunction

      // compare an accepted result with the oldest expectation
      function void check_reply(logic [2:0] status, logic [31:0] grant,
                                logic [4:0] index, logic full);
         alloc_reply_type e;
         if (replies_due.size() == 0) begin
            failures++;
            if (reports < 10) begin
               reports++;
               $display("unexpected result: status %0d addr %h index %0d full %0b",
                        status, grant, index, full);
            end
            return;
         end
         e = replies_due.pop_front();
         if (e.status !== fba_pkg::status_type'(status) || e.grant_addr !== grant ||
             e.block_index !== index || e.pool_full !== full) begin
            failures++;
            if (reports < 10) begin
               reports++;
               $display("mismatch: expected status %0d addr %h index %0d full %0b",
                        e.status, e.grant_addr, e.block_index, e.pool_full);
               $display("          got      status %0d addr %h index %0d full %0b",
                        status, grant, index, full);
            end
         end
      endfunction
   endclass

   logic            clock          = 1'b0;
   logic            reset          = 1'b1;
   logic            csr_wr_en      = 1'b0;
   logic [31:0]     csr_wr_data    = '0;
   logic            req_valid      = 1'b0;
   fba_pkg::op_type req_op         = fba_pkg::OP_ALLOC;
   logic [31:0]     req_block_addr = '0;
   logic            rsp_stall      = 1'b0;
   wire logic        req_stall;
   wire logic        rsp_valid;
   wire logic [2:0]  rsp_status;
   wire logic [31:0] rsp_grant_addr;
   wire logic [4:0]  rsp_block_index;
   wire logic        rsp_pool_full;

   alloc_scoreboard_type sb;
   int tx_gap_max   = 6;
   int rx_wait_max  = 6;
   bit rx_hold_req  = 1'b0;
   int quiet_cycles = 0;

   fixed_block_allocator_unit #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_block_addr  (req_block_addr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_grant_addr  (rsp_grant_addr),
      .rsp_block_index (rsp_block_index),
      .rsp_pool_full   (rsp_pool_full)
   );

   always #6 clock = ~clock;

   // monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_reply(rsp_status, rsp_grant_addr, rsp_block_index, rsp_pool_full);
         end
         if (req_valid && !req_stall) begin
            sb.note_word(req_op, req_block_addr);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // result side: random stalls, or one long hold when asked
   initial begin
      int wait_ticks;
      forever begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            wait_ticks  = HOLD_TICKS;
         end else begin
            wait_ticks = (rx_wait_max == 0) ? 0 : $urandom_range(0, rx_wait_max);
         end
         if (wait_ticks > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_ticks) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // offer one word after a random gap and hold it until taken
   task automatic send_word(input fba_pkg::op_type op, input logic [31:0] addr);
      int gap;
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_block_addr <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering, wait for every owed reply, then let the block settle
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_heap_base(input logic [31:0] base);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= base;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.heap_base = base;
   endtask

   // mostly block addresses, plus null, misaligned, out of range and raw noise
   function automatic logic [31:0] pick_release_addr();
      logic [31:0] base;
      int unsigned k;
      base = sb.heap_base;
      k    = $urandom_range(0, NUM_BLOCKS - 1);
      case ($urandom_range(0, 10))
         0, 1, 2, 3, 4: return base + 32'(k * BLOCK_BYTES);
         5:             return 32'h0;
         6:             return base + 32'(k * BLOCK_BYTES) + $urandom_range(1, BLOCK_BYTES - 1);
         7:             return $urandom();
         8:             return base + POOL_BYTES + $urandom_range(0, 255);
         9:             return base - $urandom_range(1, 255);
         default:       return base + $urandom_range(0, POOL_BYTES - 1);
      endcase
   endfunction

   task automatic run_phase(input int words, input int alloc_pct);
      for (int i = 0; i < words; i++) begin
         if ($urandom_range(0, 99) < alloc_pct) begin
            send_word(fba_pkg::OP_ALLOC, $urandom());
         end else begin
            send_word(fba_pkg::OP_FREE, pick_release_addr());
         end
      end
   endtask

   // main sequence
   initial begin
      logic [31:0] base;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // heap base at reset value zero
      send_word(fba_pkg::OP_ALLOC, 32'h0);
      send_word(fba_pkg::OP_ALLOC, 32'hFFFF_FFFF);
      send_word(fba_pkg::OP_FREE, 32'h0);
      send_word(fba_pkg::OP_FREE, 32'h80);
      send_word(fba_pkg::OP_FREE, 32'h80);
      send_word(fba_pkg::OP_FREE, 32'h40);
      send_word(fba_pkg::OP_FREE, POOL_BYTES - BLOCK_BYTES + 4);
      send_word(fba_pkg::OP_FREE, POOL_BYTES);
      send_word(fba_pkg::OP_FREE, 32'hFFFF_FFFF);
      send_word(fba_pkg::OP_FREE, POOL_BYTES - BLOCK_BYTES);

      // pool that wraps past the top of the address space
      drain_all();
      write_heap_base(32'hFFFF_FFC0);
      send_word(fba_pkg::OP_ALLOC, 32'h5555_AAAA);
      send_word(fba_pkg::OP_ALLOC, 32'hAAAA_5555);
      send_word(fba_pkg::OP_FREE, 32'h0);
      send_word(fba_pkg::OP_FREE, 32'h40);
      send_word(fba_pkg::OP_FREE, 32'hFFFF_FFC0);
      send_word(fba_pkg::OP_FREE, 32'hFFFF_FFBF);
      send_word(fba_pkg::OP_FREE, 32'hFFFF_FFC0 + POOL_BYTES - BLOCK_BYTES);
      send_word(fba_pkg::OP_FREE, 32'hFFFF_FFC1);

      // all-ones base
      drain_all();
      write_heap_base(32'hFFFF_FFFF);
      send_word(fba_pkg::OP_ALLOC, 32'h0);
      send_word(fba_pkg::OP_FREE, 32'hFFFF_FFFF);
      send_word(fba_pkg::OP_FREE, 32'h7F);

      // random phases: fill the pool, then mostly release
      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       base = 32'h0000_0000;
            1:       base = 32'hFFFF_FFFF;
            2:       base = 32'hFFFF_F800;
            3:       base = 32'h8000_0000;
            4:       base = $urandom() & ~32'(BLOCK_BYTES - 1);
            5:       base = 32'h0000_0080;
            default: base = $urandom();
         endcase
         drain_all();
         write_heap_base(base);
         tx_gap_max  = (p % 3 == 0) ? 6 : 0;
         rx_wait_max = (p % 3 == 2) ? 0 : 6;
         run_phase(70, 85);
         if (p == 3) rx_hold_req = 1'b1;
         run_phase(70, 25);
      end

      drain_all();
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/fba_pkg.sv
rtl/fba_ctrl.sv
rtl/fba_dpath.sv
rtl/fixed_block_allocator_unit.sv
test/tb_fixed_block_allocator_unit.sv
